FILE: hw/rtl/beacon_neighbour_table_assert.svh
// ----------------------------------------------------------------------------
// Beacon neighbour table assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BEACON_NEIGHBOUR_TABLE_ASSERT_SVH
`define BEACON_NEIGHBOUR_TABLE_ASSERT_SVH

// same-cycle implication
`define BNT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("beacon_neighbour_table: assertion failed");

// next-cycle implication
`define BNT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("beacon_neighbour_table: assertion failed");

`endif

FILE: hw/rtl/bnt_pkg.sv
// ----------------------------------------------------------------------------
// bnt_pkg
// Types and constants of the beacon neighbour table.
// ----------------------------------------------------------------------------
package bnt_pkg;

   localparam int TBL_DEPTH      = 32;
   localparam int PKT_DEPTH      = 32;
   localparam int TBL_IDX_W      = 5;
   localparam int PKT_IDX_W      = 5;
   localparam int CNT_W          = 6;
   localparam logic [7:0] LEVEL_INFINITE = 8'd255;
   localparam logic [5:0] MAX_OUT = 6'd32;

   // request codes
   localparam logic [1:0] REQ_BEACON = 2'd0;
   localparam logic [1:0] REQ_EMIT   = 2'd1;
   localparam logic [1:0] REQ_SWEEP  = 2'd2;

   // register indexes
   localparam logic [2:0] REG_OWN_ID      = 3'd0;
   localparam logic [2:0] REG_OWN_LOC_A   = 3'd1;
   localparam logic [2:0] REG_OWN_LOC_B   = 3'd2;
   localparam logic [2:0] REG_OWN_LOC_C   = 3'd3;
   localparam logic [2:0] REG_STALE_AFTER = 3'd4;
   localparam logic [2:0] REG_MAX_STRATUM = 3'd5;

   typedef struct packed {
      logic [15:0]        id;
      logic [7:0]         level;
      logic signed [15:0] loc_a;
      logic signed [15:0] loc_b;
      logic signed [15:0] loc_c;
   } entry_type;

   typedef struct packed {
      entry_type   ent;
      logic [31:0] stamp;
   } row_type;

endpackage

FILE: hw/rtl/bnt_if.sv
// ----------------------------------------------------------------------------
// bnt_if
// Channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface bnt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [15:0]        node_id;
   logic [7:0]         hop_level;
   logic signed [15:0] loc_a;
   logic signed [15:0] loc_b;
   logic signed [15:0] loc_c;
   logic               last;
   logic [31:0]        now;
   logic [5:0]         emit_limit;
   modport source (output valid, req_type, node_id, hop_level, loc_a, loc_b, loc_c,
                   last, now, emit_limit, input ready);
   modport sink   (input valid, req_type, node_id, hop_level, loc_a, loc_b, loc_c,
                   last, now, emit_limit, output ready);
endinterface

interface bnt_rsp_if;
   logic               valid;
   logic               ready;
   logic               out_valid;
   logic [15:0]        out_id;
   logic [7:0]         out_level;
   logic signed [15:0] out_loc_a;
   logic signed [15:0] out_loc_b;
   logic signed [15:0] out_loc_c;
   logic               out_last;
   modport source (output valid, out_valid, out_id, out_level, out_loc_a, out_loc_b,
                   out_loc_c, out_last, input ready);
   modport sink   (input valid, out_valid, out_id, out_level, out_loc_a, out_loc_b,
                   out_loc_c, out_last, output ready);
endinterface

interface bnt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/beacon_neighbour_table.sv
// ----------------------------------------------------------------------------
// beacon_neighbour_table
// Neighbour table fed by beacon packets, with aging sweep and emit listing.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req_ch   in         beacon record, emit request or aging sweep
//  rsp_ch   out        emitted entries, last one flagged
//  csr_ch   in         register writes, always ready
//
//  A beacon record without last is buffered. At packet end the records are
//  searched for one naming this node, then each applied record searches the
//  table and is written or dropped; the table memory read port sets the pace.
//  Emit reads and checks each entry (the self entry needs no read), registers
//  each result and waits out output stalls. Sweep reads and checks each entry.
//  Synchronous reset clears control state; no clearing pass is needed.
//  req_ch is not ready until the current item and its results are done.
// ----------------------------------------------------------------------------
module beacon_neighbour_table (
   input  logic clock,
   input  logic reset,
   bnt_req_if.sink   req_ch,
   bnt_rsp_if.source rsp_ch,
   bnt_csr_if.sink   csr_ch
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_P0_RD    = 4'd1;
   localparam logic [3:0] S_P0_CHK   = 4'd2;
   localparam logic [3:0] S_FIND_RD  = 4'd3;
   localparam logic [3:0] S_FIND_CHK = 4'd4;
   localparam logic [3:0] S_AP_RD    = 4'd5;
   localparam logic [3:0] S_AP_CHK   = 4'd6;
   localparam logic [3:0] S_SR_RD    = 4'd7;
   localparam logic [3:0] S_SR_CHK   = 4'd8;
   localparam logic [3:0] S_WR       = 4'd9;
   localparam logic [3:0] S_SW_RD    = 4'd10;
   localparam logic [3:0] S_SW_CHK   = 4'd11;
   localparam logic [3:0] S_EM_RD    = 4'd12;
   localparam logic [3:0] S_EM_CHK   = 4'd13;
   localparam logic [3:0] S_EM_OUT   = 4'd14;
   localparam logic [3:0] S_FIN      = 4'd15;

   // config registers
   logic [15:0]        own_id_ff;
   logic signed [15:0] own_loc_a_ff, own_loc_b_ff, own_loc_c_ff;
   logic [15:0]        stale_after_ff;
   logic [7:0]         max_stratum_ff;

   // control state
   logic [3:0]  state_ff, state_in;
   logic [bnt_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [bnt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [bnt_pkg::TBL_DEPTH-1:0] active_ff, active_in;
   logic [bnt_pkg::CNT_W-1:0] i_ff, i_in, n_ff, n_in, j_ff, j_in, k_ff, k_in;
   logic [bnt_pkg::CNT_W-1:0] lim_ff, lim_in;
   logic        hold_ok_ff, hold_ok_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [31:0] now_ff, now_in, limit_ff, limit_in;
   logic [7:0]  sender_ff, sender_in;
   bnt_pkg::entry_type rec_ff, rec_in, hold_ff, hold_in, rsp_ent_ff, rsp_ent_in;
   logic        rsp_ov_ff, rsp_ov_in, rsp_last_ff, rsp_last_in;

   // memories
   bnt_pkg::entry_type pkt_mem [bnt_pkg::PKT_DEPTH];
   bnt_pkg::row_type   tbl_mem [bnt_pkg::TBL_DEPTH];
   logic                          pkt_we, tbl_we;
   logic [bnt_pkg::PKT_IDX_W-1:0] pkt_waddr, pkt_raddr;
   logic [bnt_pkg::TBL_IDX_W-1:0] tbl_waddr, tbl_raddr;
   bnt_pkg::entry_type pkt_wdata, pkt_rdata_ff;
   bnt_pkg::row_type   tbl_wdata, tbl_rdata_ff;

   logic req_fire, rsp_fire;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_valid_ff && rsp_ch.ready;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_valid = rsp_ov_ff;
   assign rsp_ch.out_id    = rsp_ent_ff.id;
   assign rsp_ch.out_level = rsp_ent_ff.level;
   assign rsp_ch.out_loc_a = rsp_ent_ff.loc_a;
   assign rsp_ch.out_loc_b = rsp_ent_ff.loc_b;
   assign rsp_ch.out_loc_c = rsp_ent_ff.loc_c;
   assign rsp_ch.out_last  = rsp_last_ff;

   // memory ports
   always_ff @(posedge clock) begin
      if (pkt_we) begin
         pkt_mem[pkt_waddr] <= pkt_wdata;
      end
      pkt_rdata_ff <= pkt_mem[pkt_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rdata_ff <= tbl_mem[tbl_raddr];
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff      <= '0;
         own_loc_a_ff   <= '0;
         own_loc_b_ff   <= '0;
         own_loc_c_ff   <= '0;
         stale_after_ff <= 16'd30;
         max_stratum_ff <= 8'd4;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            bnt_pkg::REG_OWN_ID:      own_id_ff      <= csr_ch.data;
            bnt_pkg::REG_OWN_LOC_A:   own_loc_a_ff   <= csr_ch.data;
            bnt_pkg::REG_OWN_LOC_B:   own_loc_b_ff   <= csr_ch.data;
            bnt_pkg::REG_OWN_LOC_C:   own_loc_c_ff   <= csr_ch.data;
            bnt_pkg::REG_STALE_AFTER: stale_after_ff <= csr_ch.data;
            bnt_pkg::REG_MAX_STRATUM: max_stratum_ff <= csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      bnt_pkg::entry_type d, cand, self_ent;
      logic [7:0] lvl;
      logic next_rec, not_found, em_adv, qual;

      state_in     = state_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      lim_in       = lim_ff;
      hold_ok_in   = hold_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      now_in       = now_ff;
      limit_in     = limit_ff;
      sender_in    = sender_ff;
      rec_in       = rec_ff;
      hold_in      = hold_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_ov_in    = rsp_ov_ff;
      rsp_last_in  = rsp_last_ff;

      pkt_we    = 1'b0;
      pkt_waddr = fill_ff[bnt_pkg::PKT_IDX_W-1:0];
      pkt_wdata = '{id: req_ch.node_id, level: req_ch.hop_level, loc_a: req_ch.loc_a,
                    loc_b: req_ch.loc_b, loc_c: req_ch.loc_c};
      pkt_raddr = i_ff[bnt_pkg::PKT_IDX_W-1:0];
      tbl_we    = 1'b0;
      tbl_waddr = j_ff[bnt_pkg::TBL_IDX_W-1:0];
      tbl_wdata = '{ent: rec_ff, stamp: now_ff};
      tbl_raddr = j_ff[bnt_pkg::TBL_IDX_W-1:0];

      d        = pkt_rdata_ff;
      self_ent = '{id: own_id_ff, level: 8'd0, loc_a: own_loc_a_ff,
                   loc_b: own_loc_b_ff, loc_c: own_loc_c_ff};
      cand     = (j_ff == '0) ? self_ent : tbl_rdata_ff.ent;
      lvl      = '0;
      next_rec = 1'b0;
      not_found = 1'b0;
      em_adv   = 1'b0;
      qual     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in = req_ch.now;
               case (req_ch.req_type)
                  bnt_pkg::REQ_BEACON: begin
                     if (fill_ff < bnt_pkg::CNT_W'(bnt_pkg::PKT_DEPTH)) begin
                        pkt_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                     if (req_ch.last) begin
                        n_in     = fill_in;
                        fill_in  = '0;
                        state_in = S_P0_RD;
                     end
                  end
                  bnt_pkg::REQ_EMIT: begin
                     lim_in     = (req_ch.emit_limit > bnt_pkg::MAX_OUT) ?
                                  bnt_pkg::MAX_OUT : req_ch.emit_limit;
                     j_in       = '0;
                     k_in       = '0;
                     hold_ok_in = 1'b0;
                     if (lim_in == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_ov_in    = 1'b0;
                        rsp_last_in  = 1'b1;
                        rsp_ent_in   = '0;
                        state_in     = S_FIN;
                     end else begin
                        state_in = S_EM_CHK;
                     end
                  end
                  bnt_pkg::REQ_SWEEP: begin
                     if (req_ch.now >= {16'd0, stale_after_ff} &&
                         count_ff > bnt_pkg::CNT_W'(1)) begin
                        limit_in = req_ch.now - {16'd0, stale_after_ff};
                        j_in     = bnt_pkg::CNT_W'(1);
                        state_in = S_SW_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // sender record
         S_P0_RD: begin
            pkt_raddr = '0;
            state_in  = S_P0_CHK;
         end
         S_P0_CHK: begin
            if (d.id == own_id_ff) begin
               state_in = S_IDLE;
            end else begin
               sender_in = d.level;
               i_in      = bnt_pkg::CNT_W'(1);
               if (n_ff > bnt_pkg::CNT_W'(1)) begin
                  state_in = S_FIND_RD;
               end else begin
                  sender_in = bnt_pkg::LEVEL_INFINITE;
                  i_in      = '0;
                  state_in  = S_AP_RD;
               end
            end
         end

         // look for a record naming this node
         S_FIND_RD: state_in = S_FIND_CHK;
         S_FIND_CHK: begin
            if (d.id == own_id_ff &&
                (d.level == 8'd1 || d.level == bnt_pkg::LEVEL_INFINITE)) begin
               i_in     = '0;
               state_in = S_AP_RD;
            end else if (i_ff + 1'b1 == n_ff) begin
               n_in      = bnt_pkg::CNT_W'(1);
               sender_in = bnt_pkg::LEVEL_INFINITE;
               i_in      = '0;
               state_in  = S_AP_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end

         // apply records
         S_AP_RD: state_in = S_AP_CHK;
         S_AP_CHK: begin
            if (d.id == own_id_ff) begin
               next_rec = 1'b1;
            end else begin
               lvl = (i_ff == '0) ? sender_ff : d.level;
               rec_in       = d;
               rec_in.level = (lvl >= bnt_pkg::LEVEL_INFINITE - 8'd1) ?
                              bnt_pkg::LEVEL_INFINITE : lvl + 8'd1;
               j_in = bnt_pkg::CNT_W'(1);
               if (count_ff > bnt_pkg::CNT_W'(1)) begin
                  state_in = S_SR_RD;
               end else begin
                  not_found = 1'b1;
               end
            end
         end
         S_SR_RD: state_in = S_SR_CHK;
         S_SR_CHK: begin
            if (tbl_rdata_ff.ent.id == rec_ff.id) begin
               if (active_ff[j_ff[bnt_pkg::TBL_IDX_W-1:0]] &&
                   tbl_rdata_ff.ent.level < rec_ff.level) begin
                  next_rec = 1'b1;
               end else begin
                  state_in = S_WR;
               end
            end else if (j_ff + 1'b1 == count_ff) begin
               not_found = 1'b1;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_SR_RD;
            end
         end
         S_WR: begin
            tbl_we = 1'b1;
            active_in[j_ff[bnt_pkg::TBL_IDX_W-1:0]] = 1'b1;
            next_rec = 1'b1;
         end

         // aging sweep
         S_SW_RD: state_in = S_SW_CHK;
         S_SW_CHK: begin
            if (tbl_rdata_ff.stamp < limit_ff) begin
               active_in[j_ff[bnt_pkg::TBL_IDX_W-1:0]] = 1'b0;
            end
            if (j_ff + 1'b1 == count_ff) begin
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end

         // emit scan; one qualifying entry is held back to know out_last
         S_EM_RD: state_in = S_EM_CHK;
         S_EM_CHK: begin
            if (j_ff == '0) begin
               qual = (8'd0 < max_stratum_ff);
            end else begin
               qual = active_ff[j_ff[bnt_pkg::TBL_IDX_W-1:0]] &&
                      (cand.level < max_stratum_ff ||
                       cand.level == bnt_pkg::LEVEL_INFINITE);
            end
            if (!qual) begin
               em_adv = 1'b1;
            end else if (!hold_ok_ff) begin
               hold_in    = cand;
               hold_ok_in = 1'b1;
               k_in       = bnt_pkg::CNT_W'(1);
               if (lim_ff == bnt_pkg::CNT_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_ov_in    = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_ent_in   = cand;
                  state_in     = S_FIN;
               end else begin
                  em_adv = 1'b1;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_ov_in    = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_ent_in   = hold_ff;
               hold_in      = cand;
               k_in         = k_ff + 1'b1;
               state_in     = S_EM_OUT;
            end
         end
         S_EM_OUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (k_ff == lim_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_ov_in    = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_ent_in   = hold_ff;
                  state_in     = S_FIN;
               end else begin
                  em_adv = 1'b1;
               end
            end
         end
         S_FIN: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // no table match: append unless full
      if (not_found) begin
         if (count_ff < bnt_pkg::CNT_W'(bnt_pkg::TBL_DEPTH)) begin
            j_in     = count_ff;
            count_in = count_ff + 1'b1;
            state_in = S_WR;
         end else begin
            next_rec = 1'b1;
         end
      end

      // step to the next packet record
      if (next_rec) begin
         if (i_ff + 1'b1 == n_ff) begin
            state_in = S_IDLE;
         end else begin
            i_in     = i_ff + 1'b1;
            state_in = S_AP_RD;
         end
      end

      // step to the next table entry, or close the reply
      if (em_adv) begin
         if (j_ff + 1'b1 == count_ff) begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_ov_in    = hold_ok_in;
            rsp_ent_in   = hold_ok_in ? hold_in : '0;
            state_in     = S_FIN;
         end else begin
            j_in     = j_ff + 1'b1;
            state_in = S_EM_RD;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         count_ff     <= bnt_pkg::CNT_W'(1);
         active_ff    <= '0;
         i_ff         <= '0;
         n_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         lim_ff       <= '0;
         hold_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         i_ff         <= i_in;
         n_ff         <= n_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         lim_ff       <= lim_in;
         hold_ok_ff   <= hold_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      limit_ff    <= limit_in;
      sender_ff   <= sender_in;
      rec_ff      <= rec_in;
      hold_ff     <= hold_in;
      rsp_ent_ff  <= rsp_ent_in;
      rsp_ov_ff   <= rsp_ov_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

FILE: hw/rtl/bnt_checker.sv
// ----------------------------------------------------------------------------
// bnt_checker
// Port-level checks of the beacon neighbour table, bound to the top level.
// ----------------------------------------------------------------------------
`include "beacon_neighbour_table_assert.svh"

module bnt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_out_valid,
   input logic rsp_out_last
);

   // a pending result holds until its transfer
   `BNT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // no new request while a result is outstanding
   `BNT_ASSERT_IMPLY(a_busy_rsp, clock, reset, rsp_valid, !req_ready)

   // an empty reply is always the final one
   `BNT_ASSERT_IMPLY(a_empty_last, clock, reset, rsp_valid && !rsp_out_valid, rsp_out_last)

   // a request transfer: right after, no result is pending while ready
   `BNT_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready && !rsp_valid,
                    !rsp_valid || !req_ready)

endmodule

bind beacon_neighbour_table bnt_checker u_bnt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_valid (rsp_ch.out_valid),
   .rsp_out_last  (rsp_ch.out_last)
);
